FILE: sv/lrpe_pkg.sv
// ----------------------------------------------------------------------------
// lrpe_pkg
// Shared types, constants and state encoding for the reflectance line
// position estimator.
// ----------------------------------------------------------------------------
package lrpe_pkg;

  localparam int NUM_SENSORS = 5;
  localparam int SAMPLE_BITS = 10;
  localparam int LEVEL_BITS  = 10;
  localparam int POS_BITS    = 12;
  localparam int CNT_BITS    = 4;
  localparam int IDX_BITS    = $clog2(NUM_SENSORS);
  localparam int WEIGHT_BITS = 12;
  localparam int PROD_BITS   = SAMPLE_BITS + WEIGHT_BITS;
  localparam int WSUM_BITS   = 24;
  localparam int TOT_BITS    = 13;
  localparam int DIV_QBITS   = 12;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [LEVEL_BITS-1:0]  level_t;
  typedef logic [POS_BITS-1:0]    pos_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  localparam level_t FULL_SCALE    = 10'd1000;
  localparam level_t ON_LINE_LEVEL = 10'd300;
  localparam level_t NOISE_LEVEL   = 10'd50;
  localparam pos_t   POS_RIGHT     = 12'd4000;
  localparam pos_t   POS_CENTER    = 12'd2000;
  localparam idx_t   LAST_IDX      = IDX_BITS'(NUM_SENSORS - 1);

  typedef struct packed {
    logic    mode;
    sample_t raw_0;
    sample_t raw_1;
    sample_t raw_2;
    sample_t raw_3;
    sample_t raw_4;
  } in_item_t;

  typedef struct packed {
    pos_t   position;
    logic   on_line;
    level_t level_0;
    level_t level_1;
    level_t level_2;
    level_t level_3;
    level_t level_4;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL,
    ST_LVL_START,
    ST_LVL_WAIT,
    ST_ACCUM,
    ST_POS_START,
    ST_POS_WAIT,
    ST_FIN
  } state_t;

  // Position weight of a sensor: 1000 per index.
  function automatic weight_t sensor_weight(idx_t idx);
    weight_t w;
    w = weight_t'(idx) * weight_t'(FULL_SCALE);
    return w;
  endfunction

endpackage

FILE: sv/lrpe_div.sv
// ----------------------------------------------------------------------------
// lrpe_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in QW bits.
// ----------------------------------------------------------------------------
module lrpe_div #(
  parameter int DW = 24,
  parameter int VW = 13,
  parameter int QW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] num_r, num_nxt;
  logic [VW-1:0] div_r, div_nxt;
  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem_r, num_r[QW-1]};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(QW);
      rem_nxt  = VW'(dividend[DW-1:QW]);
      num_nxt  = dividend[QW-1:0];
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? VW'(trial - {1'b0, div_r}) : trial[VW-1:0];
      num_nxt = {num_r[QW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

FILE: sv/reflectance_line_position_estimator_top.sv
// ----------------------------------------------------------------------------
// reflectance_line_position_estimator_top
// Calibrates five reflectance sensors and turns a sample set into a line
// position with per-sensor levels.
// ----------------------------------------------------------------------------
// One item is worked at a time; in_ready is high only while the block is
// idle. A calibration item updates the window min/max and bounds of each
// sensor in turn. A line item does, per sensor, a bounds check, a level
// division on the shared divider when the sample lies strictly inside its
// bounds, and an accumulate step; then the position division when the line
// is seen with a nonzero total, and last the hand-off of the result to the
// output register. The 12-step restoring divider and the single multiplier
// are shared among the line item steps. The result register lets a new item
// be taken while a finished result still waits for its transfer.
// Calibration items give no result.
// ----------------------------------------------------------------------------
module reflectance_line_position_estimator_top #(
  parameter int CAL_SAMPLES = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  lrpe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lrpe_pkg::out_item_t out_data
);

  localparam int N = lrpe_pkg::NUM_SENSORS;

  lrpe_pkg::state_t state_r, state_nxt;

  // Captured item and the sensor being worked on.
  lrpe_pkg::in_item_t item_r, item_nxt;
  lrpe_pkg::idx_t     idx_r, idx_nxt;
  lrpe_pkg::sample_t  raw_a [N];

  logic pol_r;

  // Calibration state.
  lrpe_pkg::sample_t low_r  [N];
  lrpe_pkg::sample_t low_nxt [N];
  lrpe_pkg::sample_t high_r [N];
  lrpe_pkg::sample_t high_nxt [N];
  lrpe_pkg::sample_t wmax_r [N];
  lrpe_pkg::sample_t wmax_nxt [N];
  lrpe_pkg::sample_t wmin_r [N];
  lrpe_pkg::sample_t wmin_nxt [N];
  lrpe_pkg::cnt_t    cnt_r, cnt_nxt;

  // Line read datapath.
  lrpe_pkg::level_t  lvl_r, lvl_nxt;
  lrpe_pkg::level_t  lvls_r [N];
  lrpe_pkg::level_t  lvls_nxt [N];
  logic              on_line_r, on_line_nxt;
  logic [lrpe_pkg::WSUM_BITS-1:0] wsum_r, wsum_nxt;
  logic [lrpe_pkg::TOT_BITS-1:0]  total_r, total_nxt;
  lrpe_pkg::pos_t    pos_r, pos_nxt;
  lrpe_pkg::pos_t    lastpos_r, lastpos_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  lrpe_pkg::out_item_t out_r, out_nxt;
  logic                out_load;

  // Shared multiplier and divider.
  lrpe_pkg::sample_t                mul_a;
  lrpe_pkg::weight_t                mul_b;
  logic [lrpe_pkg::PROD_BITS-1:0]   product;
  logic                             div_start;
  logic [lrpe_pkg::WSUM_BITS-1:0]   div_dividend;
  logic [lrpe_pkg::TOT_BITS-1:0]    div_divisor;
  logic                             div_done;
  logic [lrpe_pkg::DIV_QBITS-1:0]   div_quot;

  // Current sensor views.
  lrpe_pkg::sample_t cur_raw, cur_lo, cur_hi, diff;
  logic              lvl_zero, lvl_full, lvl_direct;
  logic              win_first, win_end;
  lrpe_pkg::sample_t new_max, new_min;
  lrpe_pkg::level_t  lvl_pre;
  logic              pos_valid;

  assign raw_a[0] = item_r.raw_0;
  assign raw_a[1] = item_r.raw_1;
  assign raw_a[2] = item_r.raw_2;
  assign raw_a[3] = item_r.raw_3;
  assign raw_a[4] = item_r.raw_4;

  assign cur_raw = raw_a[idx_r];
  assign cur_lo  = low_r[idx_r];
  assign cur_hi  = high_r[idx_r];
  assign diff    = cur_raw - cur_lo;

  // Bounds not in order (high <= low) or sample at/below low bound give a raw
  // level of 0; at/above high gives full scale; both skip the divider.
  assign lvl_zero   = (cur_hi <= cur_lo) || (cur_raw <= cur_lo);
  assign lvl_full   = (cur_raw >= cur_hi);
  assign lvl_direct = lvl_zero || lvl_full;

  assign win_first = (cnt_r == '0);
  assign win_end   = (cnt_r == lrpe_pkg::CNT_BITS'(CAL_SAMPLES - 1));
  assign new_max   = (win_first || cur_raw > wmax_r[idx_r]) ? cur_raw : wmax_r[idx_r];
  assign new_min   = (win_first || cur_raw < wmin_r[idx_r]) ? cur_raw : wmin_r[idx_r];

  assign pos_valid = on_line_r && (total_r != '0);

  // Multiplier operands: scale numerator while checking bounds, position
  // weight while accumulating.
  always_comb begin
    if (state_r == lrpe_pkg::ST_ACCUM) begin
      mul_a = lrpe_pkg::sample_t'(lvl_r);
      mul_b = lrpe_pkg::sensor_weight(idx_r);
    end else begin
      mul_a = diff;
      mul_b = lrpe_pkg::weight_t'(lrpe_pkg::FULL_SCALE);
    end
  end

  assign product = lrpe_pkg::PROD_BITS'(mul_a) * lrpe_pkg::PROD_BITS'(mul_b);

  lrpe_div #(
    .DW (lrpe_pkg::WSUM_BITS),
    .VW (lrpe_pkg::TOT_BITS),
    .QW (lrpe_pkg::DIV_QBITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign out_load = (state_r == lrpe_pkg::ST_FIN) && (!out_valid_r || out_ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrpe_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_data.mode ? lrpe_pkg::ST_LVL_START : lrpe_pkg::ST_CAL;
        end
      end
      lrpe_pkg::ST_CAL: begin
        if (idx_r == lrpe_pkg::LAST_IDX) begin
          state_nxt = lrpe_pkg::ST_IDLE;
        end
      end
      lrpe_pkg::ST_LVL_START: begin
        state_nxt = lvl_direct ? lrpe_pkg::ST_ACCUM : lrpe_pkg::ST_LVL_WAIT;
      end
      lrpe_pkg::ST_LVL_WAIT: begin
        if (div_done) begin
          state_nxt = lrpe_pkg::ST_ACCUM;
        end
      end
      lrpe_pkg::ST_ACCUM: begin
        state_nxt = (idx_r == lrpe_pkg::LAST_IDX) ? lrpe_pkg::ST_POS_START
                                                  : lrpe_pkg::ST_LVL_START;
      end
      lrpe_pkg::ST_POS_START: begin
        state_nxt = pos_valid ? lrpe_pkg::ST_POS_WAIT : lrpe_pkg::ST_FIN;
      end
      lrpe_pkg::ST_POS_WAIT: begin
        if (div_done) begin
          state_nxt = lrpe_pkg::ST_FIN;
        end
      end
      lrpe_pkg::ST_FIN: begin
        if (out_load) begin
          state_nxt = lrpe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lrpe_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    item_nxt     = item_r;
    idx_nxt      = idx_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    wmax_nxt     = wmax_r;
    wmin_nxt     = wmin_r;
    cnt_nxt      = cnt_r;
    lvl_nxt      = lvl_r;
    lvls_nxt     = lvls_r;
    on_line_nxt  = on_line_r;
    wsum_nxt     = wsum_r;
    total_nxt    = total_r;
    pos_nxt      = pos_r;
    lastpos_nxt  = lastpos_r;
    div_start    = 1'b0;
    div_dividend = lrpe_pkg::WSUM_BITS'(product);
    div_divisor  = lrpe_pkg::TOT_BITS'(cur_hi - cur_lo);
    lvl_pre      = '0;

    case (state_r)
      lrpe_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_data;
          idx_nxt     = '0;
          on_line_nxt = 1'b0;
          wsum_nxt    = '0;
          total_nxt   = '0;
        end
      end
      lrpe_pkg::ST_CAL: begin
        wmax_nxt[idx_r] = new_max;
        wmin_nxt[idx_r] = new_min;
        if (win_end) begin
          if (new_min > cur_hi) high_nxt[idx_r] = new_min;
          if (new_max < cur_lo) low_nxt[idx_r]  = new_max;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == lrpe_pkg::LAST_IDX) begin
          cnt_nxt = win_end ? '0 : cnt_r + 1'b1;
        end
      end
      lrpe_pkg::ST_LVL_START: begin
        if (lvl_direct) begin
          lvl_pre = lvl_zero ? '0 : lrpe_pkg::FULL_SCALE;
          lvl_nxt = pol_r ? lvl_pre : lrpe_pkg::FULL_SCALE - lvl_pre;
        end else begin
          div_start = 1'b1;
        end
      end
      lrpe_pkg::ST_LVL_WAIT: begin
        if (div_done) begin
          lvl_pre = div_quot[lrpe_pkg::LEVEL_BITS-1:0];
          lvl_nxt = pol_r ? lvl_pre : lrpe_pkg::FULL_SCALE - lvl_pre;
        end
      end
      lrpe_pkg::ST_ACCUM: begin
        lvls_nxt[idx_r] = lvl_r;
        if (lvl_r > lrpe_pkg::ON_LINE_LEVEL) on_line_nxt = 1'b1;
        if (lvl_r > lrpe_pkg::NOISE_LEVEL) begin
          wsum_nxt  = wsum_r + lrpe_pkg::WSUM_BITS'(product);
          total_nxt = total_r + lrpe_pkg::TOT_BITS'(lvl_r);
        end
        idx_nxt = idx_r + 1'b1;
      end
      lrpe_pkg::ST_POS_START: begin
        div_dividend = wsum_r;
        div_divisor  = total_r;
        if (pos_valid) begin
          div_start = 1'b1;
        end else begin
          // Off the line: snap to the side last seen, memory untouched.
          pos_nxt = (lastpos_r < lrpe_pkg::POS_CENTER) ? '0 : lrpe_pkg::POS_RIGHT;
        end
      end
      lrpe_pkg::ST_POS_WAIT: begin
        if (div_done) begin
          pos_nxt     = div_quot;
          lastpos_nxt = div_quot;
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_comb begin
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt    = 1'b1;
      out_nxt.position = pos_r;
      out_nxt.on_line  = on_line_r;
      out_nxt.level_0  = lvls_r[0];
      out_nxt.level_1  = lvls_r[1];
      out_nxt.level_2  = lvls_r[2];
      out_nxt.level_3  = lvls_r[3];
      out_nxt.level_4  = lvls_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrpe_pkg::ST_IDLE;
      pol_r       <= 1'b0;
      cnt_r       <= '0;
      lastpos_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < N; i++) begin
        low_r[i]  <= '1;
        high_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lastpos_r   <= lastpos_nxt;
      out_valid_r <= out_valid_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      if (cfg_wr_en) begin
        pol_r <= cfg_wr_data;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    idx_r     <= idx_nxt;
    wmax_r    <= wmax_nxt;
    wmin_r    <= wmin_nxt;
    lvl_r     <= lvl_nxt;
    lvls_r    <= lvls_nxt;
    on_line_r <= on_line_nxt;
    wsum_r    <= wsum_nxt;
    total_r   <= total_nxt;
    pos_r     <= pos_nxt;
    out_r     <= out_nxt;
  end

  assign in_ready  = (state_r == lrpe_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: sv/lrpe_checker.sv
// ----------------------------------------------------------------------------
// lrpe_checker
// Port-level checks for the line position estimator, bound to the top level.
// ----------------------------------------------------------------------------
module lrpe_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input lrpe_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input lrpe_pkg::out_item_t out_data
);

  // One item at a time: a transfer closes the input until the work is done.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  // A new result only follows a busy cycle.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

  // Off the line the position snaps to an end.
  a_off_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.on_line |->
      out_data.position == '0 || out_data.position == lrpe_pkg::POS_RIGHT)
    else $error("off-line position not at an end");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A waiting input transfer keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input payload changed while waiting");

endmodule

bind reflectance_line_position_estimator_top lrpe_checker u_lrpe_checker (.*);
